// ===== rtl/core/bcts_pkg.sv =====
// types, codes and reset constants for the battery capacity test sequencer
// no dependencies; used by every module of the block
`default_nettype none

package bcts_pkg;

    localparam int CODE_W     = 10;
    localparam int DIFF_W     = 11;
    localparam int INTERVAL_W = 16;
    localparam int ELAPSED_W  = 24;
    localparam int SUM_W      = 28;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 32;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 80;

    localparam logic [CODE_W-1:0]     FULL_VOLTAGE_RESET    = 10'd947;
    localparam logic [CODE_W-1:0]     PRESENT_VOLTAGE_RESET = 10'd879;
    localparam logic [CODE_W-1:0]     REST_VOLTAGE_RESET    = 10'd892;
    localparam logic [CODE_W-1:0]     END_VOLTAGE_RESET     = 10'd676;
    localparam logic [DIFF_W-1:0]     FULL_CURRENT_RESET    = 11'h7EC;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET        = 16'd59;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_CHARGE    = 3'd1,
        PH_REST      = 3'd2,
        PH_DISCHARGE = 3'd3,
        PH_DONE      = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_TICK   = 2'd1,
        OP_SAMPLE = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_VOLTAGE    = 3'd0,
        CFG_PRESENT_VOLTAGE = 3'd1,
        CFG_REST_VOLTAGE    = 3'd2,
        CFG_END_VOLTAGE     = 3'd3,
        CFG_FULL_CURRENT    = 3'd4,
        CFG_INTERVAL        = 3'd5,
        CFG_RECHARGE        = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [CODE_W-1:0]        full_voltage_code;
        logic [CODE_W-1:0]        present_voltage_code;
        logic [CODE_W-1:0]        rest_voltage_code;
        logic [CODE_W-1:0]        end_voltage_code;
        logic signed [DIFF_W-1:0] full_current_limit;
        logic [INTERVAL_W-1:0]    accumulate_interval;
        logic                     recharge_at_end;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [CODE_W-1:0] voltage_code;
        logic [CODE_W-1:0] current_ref_code;
        logic [CODE_W-1:0] current_sense_code;
    } item_t;

    typedef struct packed {
        phase_t                  phase;
        logic                    charger;
        logic                    load;
        logic                    error;
        logic [ELAPSED_W-1:0]    elapsed;
        logic [ELAPSED_W-1:0]    last_acc;
        logic signed [SUM_W-1:0] sum;
        logic [COUNT_W-1:0]      count;
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/bcts_cfg.sv =====
// configuration register file of the test sequencer
// depends on bcts_pkg for the register index codes and reset values
`default_nettype none

module bcts_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [bcts_pkg::CFG_IDX_W-1:0]     wr_index,
    input  wire logic [bcts_pkg::CFG_DATA_W-1:0]    wr_data,
    output bcts_pkg::cfg_t                          cfg
);
    import bcts_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_FULL_VOLTAGE:    cfg_next.full_voltage_code    = wr_data[CODE_W-1:0];
                CFG_PRESENT_VOLTAGE: cfg_next.present_voltage_code = wr_data[CODE_W-1:0];
                CFG_REST_VOLTAGE:    cfg_next.rest_voltage_code    = wr_data[CODE_W-1:0];
                CFG_END_VOLTAGE:     cfg_next.end_voltage_code     = wr_data[CODE_W-1:0];
                CFG_FULL_CURRENT:    cfg_next.full_current_limit   = $signed(wr_data[DIFF_W-1:0]);
                CFG_INTERVAL:        cfg_next.accumulate_interval  = wr_data[INTERVAL_W-1:0];
                CFG_RECHARGE:        cfg_next.recharge_at_end      = wr_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_voltage_code    <= FULL_VOLTAGE_RESET;
            cfg_reg.present_voltage_code <= PRESENT_VOLTAGE_RESET;
            cfg_reg.rest_voltage_code    <= REST_VOLTAGE_RESET;
            cfg_reg.end_voltage_code     <= END_VOLTAGE_RESET;
            cfg_reg.full_current_limit   <= $signed(FULL_CURRENT_RESET);
            cfg_reg.accumulate_interval  <= INTERVAL_RESET;
            cfg_reg.recharge_at_end      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bcts_step.sv =====
// next-state logic of the test sequencer: one item against the current state
// depends on bcts_pkg for the phase, op, config and state types
`default_nettype none

module bcts_step (
    input  bcts_pkg::state_t state,
    input  bcts_pkg::cfg_t   cfg,
    input  bcts_pkg::item_t  item,
    output bcts_pkg::state_t state_next
);
    import bcts_pkg::*;

    logic signed [DIFF_W-1:0]  diff;
    logic                      charge_cont;
    logic                      charger_present;
    logic [ELAPSED_W-1:0]      since_acc;
    logic                      acc_due;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;
    logic                      rest_end;
    logic                      discharge_end;
    phase_t                    phase_next;

    assign diff = $signed({1'b0, item.current_sense_code})
                - $signed({1'b0, item.current_ref_code});

    assign charge_cont     = (diff < cfg.full_current_limit)
                          || (item.voltage_code < cfg.full_voltage_code);
    assign charger_present = (item.voltage_code > cfg.present_voltage_code) || diff[DIFF_W-1];
    assign rest_end        = item.voltage_code <= cfg.rest_voltage_code;
    assign discharge_end   = item.voltage_code <= cfg.end_voltage_code;

    // time since last accumulation wraps in the counter width
    assign since_acc = state.elapsed - state.last_acc;
    assign acc_due   = since_acc >= {{(ELAPSED_W-INTERVAL_W){1'b0}}, cfg.accumulate_interval};

    assign sum_wide = {state.sum[SUM_W-1], state.sum}
                    + {{(SUM_W+1-DIFF_W){diff[DIFF_W-1]}}, diff};

    always_comb
    begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    // phase transitions
    always_comb
    begin
        phase_next = state.phase;
        unique case (item.op)
            OP_START:
            begin
                phase_next = PH_CHARGE;
            end
            OP_SAMPLE:
            begin
                unique case (state.phase)
                    PH_CHARGE:    phase_next = charge_cont ? PH_CHARGE : PH_REST;
                    PH_REST:      phase_next = rest_end ? PH_DISCHARGE : PH_REST;
                    PH_DISCHARGE: phase_next = discharge_end ? PH_DONE : PH_DISCHARGE;
                    default:      phase_next = state.phase;
                endcase
            end
            default:
            begin
                phase_next = state.phase;
            end
        endcase
    end

    // drives, counters and accumulator
    always_comb
    begin
        state_next       = state;
        state_next.phase = phase_next;
        unique case (item.op)
            OP_START:
            begin
                state_next.charger  = 1'b1;
                state_next.load     = 1'b0;
                state_next.error    = 1'b0;
                state_next.elapsed  = '0;
                state_next.last_acc = '0;
                state_next.sum      = '0;
                state_next.count    = '0;
            end
            OP_TICK:
            begin
                if (state.phase == PH_DISCHARGE && state.elapsed != '1)
                begin
                    state_next.elapsed = state.elapsed + 1'b1;
                end
            end
            OP_SAMPLE:
            begin
                unique case (state.phase)
                    PH_CHARGE:
                    begin
                        state_next.charger = charge_cont;
                        state_next.error   = charge_cont && !charger_present;
                    end
                    PH_REST:
                    begin
                        if (rest_end)
                        begin
                            state_next.load     = 1'b1;
                            state_next.elapsed  = '0;
                            state_next.last_acc = '0;
                            state_next.count    = '0;
                        end
                    end
                    PH_DISCHARGE:
                    begin
                        if (discharge_end)
                        begin
                            state_next.load = 1'b0;
                        end
                        else if (acc_due)
                        begin
                            state_next.last_acc = state.elapsed;
                            state_next.sum      = sum_sat;
                            if (state.count != '1)
                            begin
                                state_next.count = state.count + 1'b1;
                            end
                        end
                    end
                    PH_DONE:
                    begin
                        state_next.charger = cfg.recharge_at_end && charge_cont;
                    end
                    default:
                    begin
                        state_next = state;
                    end
                endcase
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/battery_capacity_test_sequencer_core.sv =====
// top level of the battery capacity test sequencer
// depends on bcts_pkg, bcts_cfg and bcts_step
//
// Usage:
//   s_* carries items in: s_tuser is the op (start, second tick, ADC sample),
//   s_tdata the voltage, current reference and current sense codes.
//   m_* carries one result per item: the phase, charger and load drives,
//   the charge error flag, elapsed seconds, current sum and sample count,
//   all as they stand after that item.
//   cfg_* writes the threshold registers; cfg_ready is always high and
//   writes are expected only while no item is in flight.
// Pipeline and throughput:
//   an item is registered in item_reg on acceptance and is then evaluated
//   against the state; its result is registered in the state registers,
//   which drive m_*. One item per cycle is sustained while m_tready stays
//   high; the state registers with their update loop set that figure.
// Reset:
//   rst_n clears the phase to idle, all counters, the sum and the drives,
//   and loads the default thresholds.
// Stall:
//   while m_tready is low the result holds; one more item is taken into the
//   input register, after which s_tready drops until the result is taken.
`default_nettype none

module battery_capacity_test_sequencer_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output wire logic                              s_tready,
    // voltage_code[9:0], current_ref_code[19:10], current_sense_code[29:20], zero pad
    input  wire logic [bcts_pkg::S_DATA_W-1:0]     s_tdata,
    // op[1:0]
    input  wire logic [bcts_pkg::S_USER_W-1:0]     s_tuser,
    output wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    // phase[2:0], charger_on[3], load_on[4], charge_error[5], elapsed_seconds[29:6],
    // current_sum[57:30], sample_count[73:58], zero pad
    output wire logic [bcts_pkg::M_DATA_W-1:0]     m_tdata,
    input  wire logic                              cfg_valid,
    output wire logic                              cfg_ready,
    input  wire logic [bcts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bcts_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bcts_pkg::*;

    localparam int OUT_USED = 3 + 3 + ELAPSED_W + SUM_W + COUNT_W;

    cfg_t   cfg;
    item_t  item_reg;
    logic   in_valid_reg;
    logic   out_valid_reg;
    state_t state_reg;
    state_t state_next;
    logic   advance;
    logic   in_accept;

    assign cfg_ready = 1'b1;

    bcts_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bcts_step u_step (
        .state      (state_reg),
        .cfg        (cfg),
        .item       (item_reg),
        .state_next (state_next)
    );

    // the state registers double as the result register
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.op                 <= s_tuser[1:0];
            item_reg.voltage_code       <= s_tdata[CODE_W-1:0];
            item_reg.current_ref_code   <= s_tdata[2*CODE_W-1:CODE_W];
            item_reg.current_sense_code <= s_tdata[3*CODE_W-1:2*CODE_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_IDLE, default: '0};
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-OUT_USED){1'b0}},
                       state_reg.count,
                       state_reg.sum,
                       state_reg.elapsed,
                       state_reg.error,
                       state_reg.load,
                       state_reg.charger,
                       state_reg.phase};

    // load drive is on exactly while discharging
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.load == (state_reg.phase == PH_DISCHARGE))
        else $error("load drive out of step with phase");

    // charge error can only stand while charging
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.error |-> (state_reg.phase == PH_CHARGE))
        else $error("charge error outside charging phase");

    // accumulations happen only in discharge, cleared by start and by entering discharge
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.count != '0) |-> (state_reg.phase == PH_DISCHARGE
                                     || state_reg.phase == PH_DONE))
        else $error("sample count nonzero outside discharge or done");

    // state moves only when an item is evaluated
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without an item");

    // input side stalls only when both stages are full and the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with room downstream");

endmodule

`default_nettype wire

// ===== dv/battery_capacity_test_sequencer_core_test.sv =====
// self-checking testbench for battery_capacity_test_sequencer_core
// predicts every result from a local model of the sequencer; needs bcts_pkg and the core
`timescale 1ns / 1ps

module battery_capacity_test_sequencer_core_test;

    import bcts_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;   // unused op code, block only reports its state
    localparam int STALL_LIMIT = 2000;
    localparam int SUM_TOP = 134217727;
    localparam int SUM_BOTTOM = -134217728;

    typedef struct {
        logic [1:0]        op;
        logic [CODE_W-1:0] volt;
        logic [CODE_W-1:0] ref_code;
        logic [CODE_W-1:0] sense;
    } stim_t;

    typedef struct {
        logic [2:0]              phase;
        logic                    charger;
        logic                    load;
        logic                    error;
        logic [ELAPSED_W-1:0]    elapsed;
        logic signed [SUM_W-1:0] sum;
        logic [COUNT_W-1:0]      count;
    } seq_status_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [S_USER_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // threshold copy, follows every accepted register write
    logic [CODE_W-1:0]        cfg_full_v    = FULL_VOLTAGE_RESET;
    logic [CODE_W-1:0]        cfg_present_v = PRESENT_VOLTAGE_RESET;
    logic [CODE_W-1:0]        cfg_rest_v    = REST_VOLTAGE_RESET;
    logic [CODE_W-1:0]        cfg_end_v     = END_VOLTAGE_RESET;
    logic signed [DIFF_W-1:0] cfg_limit     = FULL_CURRENT_RESET;
    logic [INTERVAL_W-1:0]    cfg_interval  = INTERVAL_RESET;
    logic                     cfg_recharge  = 1'b0;

    // sequencer state as predicted
    phase_t                  ph_q       = PH_IDLE;
    logic                    chg_q      = 1'b0;
    logic                    load_q     = 1'b0;
    logic                    err_q      = 1'b0;
    logic [ELAPSED_W-1:0]    elapsed_q  = '0;
    logic [ELAPSED_W-1:0]    last_acc_q = '0;
    logic signed [SUM_W-1:0] sum_q      = '0;
    logic [COUNT_W-1:0]      count_q    = '0;

    stim_t       pending_items[$];
    seq_status_t expected_status[$];

    int  queued = 0;
    int  mismatches = 0;
    int  results_seen = 0;
    int  next_hold_at = 100;
    int  quiet_cycles = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  rx_hold = 0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;
    bit  tx_offer;

    battery_capacity_test_sequencer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic seq_status_t step_sequencer(stim_t it);
        int diff;
        int lim;
        int acc;
        bit keep_charging;
        seq_status_t st;
        diff = int'(it.sense) - int'(it.ref_code);
        lim = cfg_limit;
        keep_charging = (diff < lim) || (it.volt < cfg_full_v);
        case (it.op)
            OP_START:
            begin
                ph_q = PH_CHARGE;
                chg_q = 1'b1;
                load_q = 1'b0;
                err_q = 1'b0;
                elapsed_q = '0;
                last_acc_q = '0;
                sum_q = '0;
                count_q = '0;
            end
            OP_TICK:
                if (ph_q == PH_DISCHARGE && elapsed_q != '1)
                    elapsed_q++;
            OP_SAMPLE:
                case (ph_q)
                    PH_CHARGE:
                        if (!keep_charging)
                        begin
                            ph_q = PH_REST;
                            chg_q = 1'b0;
                            err_q = 1'b0;
                        end
                        else
                        begin
                            chg_q = 1'b1;
                            // charger looks absent: voltage low and current not flowing in
                            err_q = !(it.volt > cfg_present_v || diff < 0);
                        end
                    PH_REST:
                        if (it.volt <= cfg_rest_v)
                        begin
                            ph_q = PH_DISCHARGE;
                            load_q = 1'b1;
                            elapsed_q = '0;
                            last_acc_q = '0;
                            count_q = '0;
                        end
                    PH_DISCHARGE:
                        if (it.volt <= cfg_end_v)
                        begin
                            ph_q = PH_DONE;
                            load_q = 1'b0;
                        end
                        else if (ELAPSED_W'(elapsed_q - last_acc_q) >= ELAPSED_W'(cfg_interval))
                        begin
                            last_acc_q = elapsed_q;
                            if (count_q != '1)
                                count_q++;
                            acc = int'(sum_q) + diff;
                            if (acc > SUM_TOP)
                                acc = SUM_TOP;
                            if (acc < SUM_BOTTOM)
                                acc = SUM_BOTTOM;
                            sum_q = acc[SUM_W-1:0];
                        end
                    PH_DONE:
                        chg_q = cfg_recharge && keep_charging;
                    default: ;
                endcase
            default: ;
        endcase
        st.phase = ph_q;
        st.charger = chg_q;
        st.load = load_q;
        st.error = err_q;
        st.elapsed = elapsed_q;
        st.sum = sum_q;
        st.count = count_q;
        return st;
    endfunction

    task automatic report(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want)
            report($sformatf("result %0d %s got %0d want %0d", results_seen, name, got, want));
    endtask

    task automatic check_result(logic [M_DATA_W-1:0] word);
        seq_status_t want;
        if (expected_status.size() == 0)
        begin
            report($sformatf("result %0d arrived with nothing expected", results_seen));
            return;
        end
        want = expected_status.pop_front();
        check_field("phase", word[2:0], want.phase);
        check_field("charger_on", word[3], want.charger);
        check_field("load_on", word[4], want.load);
        check_field("charge_error", word[5], want.error);
        check_field("elapsed_seconds", word[29:6], want.elapsed);
        check_field("current_sum", longint'($signed(word[57:30])), longint'(want.sum));
        check_field("sample_count", word[73:58], want.count);
        check_field("pad", word[79:74], 0);
    endtask

    // item driver: one draw of idle cycles per item, with bursts of back-to-back items
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            tx_offer = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                expected_status.push_back(step_sequencer(pending_items.pop_front()));
                tx_offer = 1'b0;
                if ($urandom_range(39, 0) == 0)
                    tx_burst = !tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(12, 0);
            end
            if (!tx_offer)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (pending_items.size() > 0)
                    tx_offer = 1'b1;
            end
            if (tx_offer)
            begin
                s_tdata <= {2'b00, pending_items[0].sense, pending_items[0].ref_code,
                            pending_items[0].volt};
                s_tuser <= pending_items[0].op;
            end
            else
            begin
                s_tdata <= $urandom;
                s_tuser <= 2'($urandom_range(3, 0));
            end
            s_tvalid <= tx_offer;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                check_result(m_tdata);
                results_seen++;
                // long hold-off while plenty is queued so the block backs up
                if (results_seen >= next_hold_at && pending_items.size() >= 40)
                begin
                    rx_hold = 400;
                    next_hold_at = results_seen + 700;
                end
                if ($urandom_range(39, 0) == 0)
                    rx_burst = !rx_burst;
                rx_gap = rx_burst ? 0 : $urandom_range(12, 0);
            end
            else if (rx_hold > 0)
                rx_hold--;
            else if (rx_gap > 0)
                rx_gap--;
            m_tready <= (rx_gap == 0) && (rx_hold == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void add_item(logic [1:0] op, int v, int r, int s);
        stim_t it;
        it.op = op;
        it.volt = v[CODE_W-1:0];
        it.ref_code = r[CODE_W-1:0];
        it.sense = s[CODE_W-1:0];
        pending_items.push_back(it);
        queued++;
    endfunction

    // sample with voltage in [v_lo, v_hi] and current difference in [d_lo, d_hi], ends favored
    function automatic void add_sample(int v_lo, int v_hi, int d_lo, int d_hi);
        int v;
        int d;
        int r;
        v = v_lo + int'($urandom_range(v_hi - v_lo, 0));
        if ($urandom_range(3, 0) == 0)
            v = $urandom_range(1, 0) ? v_lo : v_hi;
        d = d_lo + int'($urandom_range(d_hi - d_lo, 0));
        if ($urandom_range(3, 0) == 0)
            d = $urandom_range(1, 0) ? d_lo : d_hi;
        r = (d >= 0) ? $urandom_range(1023 - d, 0) : $urandom_range(1023, -d);
        add_item(OP_SAMPLE, v, r, r + d);
    endfunction

    function automatic void add_noise();
        add_item($urandom_range(1, 0) ? OP_TICK : OP_NONE, $urandom_range(1023, 0),
                 $urandom_range(1023, 0), $urandom_range(1023, 0));
    endfunction

    // one capacity test: start, charge, rest, discharge, done; some are cut short, some are random items only
    function automatic void queue_run();
        int kind;
        int lim;
        int span;
        int tick_pct;
        kind = $urandom_range(9, 0);
        lim = cfg_limit;
        if (kind == 0)
        begin
            repeat ($urandom_range(6, 1))
                add_item(2'($urandom_range(3, 0)), $urandom_range(1023, 0),
                         $urandom_range(1023, 0), $urandom_range(1023, 0));
            return;
        end
        add_item(OP_START, $urandom_range(1023, 0), $urandom_range(1023, 0),
                 $urandom_range(1023, 0));
        repeat ($urandom_range(5, 0))
        begin
            if ($urandom_range(5, 0) == 0)
                add_noise();
            else if (cfg_full_v > 0 && (lim == -1023 || $urandom_range(1, 0)))
                add_sample(0, cfg_full_v - 1, -1023, 1023);
            else if (lim > -1023)
                add_sample(0, 1023, -1023, lim - 1);
            else
                add_noise();
        end
        if (kind == 1)
            return;
        add_sample(cfg_full_v, 1023, lim, 1023);
        repeat ($urandom_range(3, 0))
        begin
            if (cfg_rest_v < 1023 && $urandom_range(4, 0) != 0)
                add_sample(cfg_rest_v + 1, 1023, -1023, 1023);
            else
                add_noise();
        end
        add_sample(0, cfg_rest_v, -1023, 1023);
        if (kind == 2)
            return;
        // long discharges only where the interval is short enough to reach
        if (cfg_interval >= 20 && cfg_interval <= 100)
        begin
            span = $urandom_range(160, 60);
            tick_pct = 85;
        end
        else
        begin
            span = $urandom_range(30, 2);
            tick_pct = 50;
        end
        repeat (span)
        begin
            if (cfg_end_v == 1023 || $urandom_range(99, 0) < tick_pct)
                add_item(OP_TICK, $urandom_range(1023, 0), $urandom_range(1023, 0),
                         $urandom_range(1023, 0));
            else
                add_sample(cfg_end_v + 1, 1023, -1023, 1023);
        end
        add_sample(0, cfg_end_v, -1023, 1023);
        repeat ($urandom_range(3, 0))
            add_sample(0, 1023, -1023, 1023);
    endfunction

    function automatic void fill_phase(int n);
        int target;
        target = queued + n;
        while (queued < target)
            queue_run();
        // the last run is cut so that each phase carries exactly n items
        while (queued > target)
        begin
            void'(pending_items.pop_back());
            queued--;
        end
    endfunction

    task automatic wait_quiet();
        while (pending_items.size() != 0 || expected_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        case (idx)
            CFG_FULL_VOLTAGE:    cfg_full_v = value[CODE_W-1:0];
            CFG_PRESENT_VOLTAGE: cfg_present_v = value[CODE_W-1:0];
            CFG_REST_VOLTAGE:    cfg_rest_v = value[CODE_W-1:0];
            CFG_END_VOLTAGE:     cfg_end_v = value[CODE_W-1:0];
            CFG_FULL_CURRENT:    cfg_limit = value[DIFF_W-1:0];
            CFG_INTERVAL:        cfg_interval = value;
            CFG_RECHARGE:        cfg_recharge = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_config(int full_v, int present_v, int rest_v, int end_v, int limit,
                                int interval, bit recharge);
        logic signed [DIFF_W-1:0] lim11;
        lim11 = DIFF_W'(limit);
        write_reg(CFG_FULL_VOLTAGE, CFG_DATA_W'(full_v));
        write_reg(CFG_PRESENT_VOLTAGE, CFG_DATA_W'(present_v));
        write_reg(CFG_REST_VOLTAGE, CFG_DATA_W'(rest_v));
        write_reg(CFG_END_VOLTAGE, CFG_DATA_W'(end_v));
        write_reg(CFG_FULL_CURRENT, {5'd0, lim11});
        write_reg(CFG_INTERVAL, CFG_DATA_W'(interval));
        write_reg(CFG_RECHARGE, CFG_DATA_W'(recharge));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int fv;
        int rv;
        int ev;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default thresholds: idle ops, charge error, threshold edges
        add_item(OP_SAMPLE, 1023, 0, 1023);
        add_item(OP_TICK, 0, 0, 0);
        add_item(OP_NONE, 1023, 1023, 1023);
        add_item(OP_START, 0, 0, 0);
        add_item(OP_SAMPLE, 0, 0, 0);
        add_item(OP_SAMPLE, 1023, 1023, 0);
        add_item(OP_TICK, 0, 0, 0);
        add_item(OP_SAMPLE, 947, 0, 1023);
        add_item(OP_SAMPLE, 893, 0, 0);
        add_item(OP_SAMPLE, 892, 0, 0);
        add_item(OP_TICK, 0, 0, 0);
        add_item(OP_SAMPLE, 677, 0, 1);
        add_item(OP_SAMPLE, 676, 0, 0);
        add_item(OP_SAMPLE, 0, 0, 0);
        add_item(OP_START, 1023, 1023, 1023);
        wait_quiet();

        // zero interval accumulates every sample; recharge after the test
        apply_config(1023, 0, 1023, 0, -1023, 0, 1'b1);
        add_item(OP_START, 0, 0, 0);
        add_item(OP_SAMPLE, 1022, 0, 0);
        add_item(OP_SAMPLE, 0, 0, 0);
        add_item(OP_SAMPLE, 1023, 1023, 0);
        add_item(OP_SAMPLE, 1023, 0, 0);
        add_item(OP_SAMPLE, 1023, 0, 1023);
        add_item(OP_SAMPLE, 1023, 1023, 0);
        add_item(OP_SAMPLE, 0, 0, 0);
        add_item(OP_SAMPLE, 0, 0, 0);
        add_item(OP_SAMPLE, 1023, 0, 0);
        wait_quiet();

        apply_config(0, 1023, 0, 1023, 1023, 65535, 1'b0);
        fill_phase(110);
        wait_quiet();

        apply_config(947, 879, 892, 676, -20, 59, 1'b0);
        fill_phase(110);
        wait_quiet();

        for (int p = 0; p < 12; p++)
        begin
            if (p % 4 == 3)
                apply_config($urandom_range(1023, 0), $urandom_range(1023, 0),
                             $urandom_range(1023, 0), $urandom_range(1023, 0),
                             int'($urandom_range(2046, 0)) - 1023, $urandom_range(65535, 0),
                             1'($urandom_range(1, 0)));
            else
            begin
                fv = $urandom_range(1023, 700);
                rv = $urandom_range(fv, 400);
                ev = $urandom_range(rv, 0);
                apply_config(fv, $urandom_range(1023, 600), rv, ev,
                             int'($urandom_range(2046, 0)) - 1023,
                             (p % 4 == 0) ? $urandom_range(70, 30) : $urandom_range(8, 0),
                             1'($urandom_range(1, 0)));
            end
            fill_phase(110);
            wait_quiet();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== battery_capacity_test_sequencer_core.f =====
rtl/core/bcts_pkg.sv
rtl/core/bcts_cfg.sv
rtl/core/bcts_step.sv
rtl/core/battery_capacity_test_sequencer_core.sv
dv/battery_capacity_test_sequencer_core_test.sv
